// ===== src/tbwi_pkg.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tbwi_pkg
// Shared widths and controller/datapath interface types for the bone weight
// insertion block.
//------------------------------------------------------------------------------
package tbwi_pkg;

    localparam int VERTEX_W    = 12;
    localparam int BONE_W      = 8;
    localparam int WEIGHT_W    = 16;
    localparam int ENTRY_W     = BONE_W + WEIGHT_W;
    localparam int SHOWN_SLOTS = 4;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } tbwi_cmd_t;

    typedef struct packed {
        logic clear_last;
    } tbwi_sts_t;

endpackage

// ===== src/tbwi_ram.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tbwi_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module tbwi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tbwi_ctrl.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tbwi_ctrl
// Sequencer: clearing pass after reset, then read, insert and write back one
// word at a time, with a result register toward the output side.
//------------------------------------------------------------------------------
module tbwi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tbwi_pkg::tbwi_sts_t sts,
    output tbwi_pkg::tbwi_cmd_t cmd
);
    import tbwi_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/tbwi_datapath.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tbwi_datapath
// Slot store, sorted insertion of one (bone, weight) pair, clear counter and
// result register.
//------------------------------------------------------------------------------
module tbwi_datapath #(
    parameter int VERTEX_COUNT = 4096,
    parameter int SLOTS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbwi_pkg::tbwi_cmd_t           cmd,
    output tbwi_pkg::tbwi_sts_t           sts,
    input  logic [tbwi_pkg::VERTEX_W-1:0] vertex_index,
    input  logic [tbwi_pkg::BONE_W-1:0]   bone_id,
    input  logic [tbwi_pkg::WEIGHT_W-1:0] weight,
    output logic                          accepted,
    output logic [tbwi_pkg::SHOWN_SLOTS*tbwi_pkg::ENTRY_W-1:0] shown_row
);
    import tbwi_pkg::*;

    localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int XW     = (ADDR_W > VERTEX_W) ? ADDR_W : VERTEX_W;
    localparam int ROW_W  = SLOTS * ENTRY_W;

    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                in_range_reg;
    logic [BONE_W-1:0]   bone_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                accepted_reg;
    logic [SHOWN_SLOTS*ENTRY_W-1:0] shown_reg;

    logic [XW-1:0]       vx;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_range;
    logic [ROW_W-1:0]    old_row;
    logic [ROW_W-1:0]    new_row;
    logic [SLOTS-1:0]    lt;
    logic [SLOTS-1:0]    prior_lt;
    logic [SLOTS-1:0]    sel;
    logic [SLOTS-1:0]    sel_nz;
    logic                shift;
    logic                hit;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [SHOWN_SLOTS*ENTRY_W-1:0] shown_next;

    assign vx       = XW'(vertex_index);
    assign in_addr  = vx[ADDR_W-1:0];
    assign in_range = (32'(vertex_index) < VERTEX_COUNT);

    tbwi_ram #(
        .WIDTH (ROW_W),
        .DEPTH (VERTEX_COUNT),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.capture),
        .raddr(in_addr),
        .rdata(old_row)
    );

    // per-slot compare and shift network
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_slot
        logic [WEIGHT_W-1:0] old_w;
        assign old_w     = old_row[s*ENTRY_W +: WEIGHT_W];
        assign lt[s]     = old_w < weight_reg;
        assign sel[s]    = lt[s] && !prior_lt[s];
        assign sel_nz[s] = sel[s] && (old_w != '0);
        if (s == 0)
        begin : g_first
            assign prior_lt[s] = 1'b0;
            assign new_row[s*ENTRY_W +: ENTRY_W] = sel[s] ? {bone_reg, weight_reg}
                                                          : old_row[s*ENTRY_W +: ENTRY_W];
        end
        else
        begin : g_rest
            assign prior_lt[s] = prior_lt[s-1] || lt[s-1];
            assign new_row[s*ENTRY_W +: ENTRY_W] =
                sel[s]                 ? {bone_reg, weight_reg} :
                (prior_lt[s] && shift) ? old_row[(s-1)*ENTRY_W +: ENTRY_W] :
                                         old_row[s*ENTRY_W +: ENTRY_W];
        end
    end

    assign shift = |sel_nz;
    assign hit   = |lt;

    // first shown slots of the result, zero past the slot count or out of range
    for (genvar g = 0; g < SHOWN_SLOTS; g++)
    begin : g_shown
        if (g < SLOTS)
        begin : g_live
            assign shown_next[g*ENTRY_W +: ENTRY_W] =
                in_range_reg ? new_row[g*ENTRY_W +: ENTRY_W] : '0;
        end
        else
        begin : g_pad
            assign shown_next[g*ENTRY_W +: ENTRY_W] = '0;
        end
    end

    always_comb
    begin
        ram_we    = cmd.clear_step || (cmd.commit && in_range_reg);
        ram_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
        ram_wdata = cmd.clear_step ? '0 : new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg     <= in_addr;
            in_range_reg <= in_range;
            bone_reg     <= bone_id;
            weight_reg   <= weight;
        end
        if (cmd.commit)
        begin
            accepted_reg <= in_range_reg && hit;
            shown_reg    <= shown_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == ADDR_W'(VERTEX_COUNT - 1));
    assign accepted       = accepted_reg;
    assign shown_row      = shown_reg;

endmodule

// ===== src/top4_bone_weight_insert_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// top4_bone_weight_insert_top
// Per-vertex list of the heaviest bone influences, kept in falling weight.
//------------------------------------------------------------------------------
// a word read from the slot ram is committed to the result register once that has room
// one word in flight at a time, set by the read-modify-write of the slot ram
// the next word is taken while a result still waits in the output register
// reset: a clearing pass zeroes every word of the slot ram, in_ready low meanwhile
module top4_bone_weight_insert_top #(
    parameter int VERTEX_COUNT = 4096,
    parameter int SLOTS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tbwi_pkg::VERTEX_W-1:0] vertex_index,
    input  logic [tbwi_pkg::BONE_W-1:0]   bone_id,
    input  logic [tbwi_pkg::WEIGHT_W-1:0] weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic [tbwi_pkg::BONE_W-1:0]   slot0_bone,
    output logic [tbwi_pkg::WEIGHT_W-1:0] slot0_weight,
    output logic [tbwi_pkg::BONE_W-1:0]   slot1_bone,
    output logic [tbwi_pkg::WEIGHT_W-1:0] slot1_weight,
    output logic [tbwi_pkg::BONE_W-1:0]   slot2_bone,
    output logic [tbwi_pkg::WEIGHT_W-1:0] slot2_weight,
    output logic [tbwi_pkg::BONE_W-1:0]   slot3_bone,
    output logic [tbwi_pkg::WEIGHT_W-1:0] slot3_weight
);
    import tbwi_pkg::*;

    tbwi_cmd_t cmd;
    tbwi_sts_t sts;
    logic [SHOWN_SLOTS*ENTRY_W-1:0] shown_row;

    tbwi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tbwi_datapath #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .SLOTS       (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .vertex_index(vertex_index),
        .bone_id     (bone_id),
        .weight      (weight),
        .accepted    (accepted),
        .shown_row   (shown_row)
    );

    assign slot0_weight = shown_row[0*ENTRY_W +: WEIGHT_W];
    assign slot0_bone   = shown_row[0*ENTRY_W + WEIGHT_W +: BONE_W];
    assign slot1_weight = shown_row[1*ENTRY_W +: WEIGHT_W];
    assign slot1_bone   = shown_row[1*ENTRY_W + WEIGHT_W +: BONE_W];
    assign slot2_weight = shown_row[2*ENTRY_W +: WEIGHT_W];
    assign slot2_bone   = shown_row[2*ENTRY_W + WEIGHT_W +: BONE_W];
    assign slot3_weight = shown_row[3*ENTRY_W +: WEIGHT_W];
    assign slot3_bone   = shown_row[3*ENTRY_W + WEIGHT_W +: BONE_W];

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while one is in flight");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result overwrites an untaken result");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> (!in_ready && !cmd.commit))
        else $error("activity during clearing pass");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without result");

endmodule

// ===== tb/tb_top4_bone_weight_insert_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top4_bone_weight_insert_top
// Drives (vertex, bone, weight) words into the top-4 bone weight list and
// predicts every result from its own copy of the per-vertex slot lists. Each
// result is checked field by field against the oldest prediction. Stimulus
// keeps most words on a few hot vertices so lists fill, shift and reject, and
// both handshakes see random gaps and stalls.
//------------------------------------------------------------------------------
module tb_top4_bone_weight_insert_top;

    import tbwi_pkg::*;

    localparam int VTX_N = 4096;
    localparam int RANKS = 4;

    typedef struct packed {
        logic                               hit;
        logic [RANKS-1:0][BONE_W-1:0]       bone;
        logic [RANKS-1:0][WEIGHT_W-1:0]     wgt;
    } slot_view_t;

    class bone_rank_board;
        bit [RANKS-1:0][WEIGHT_W-1:0] rank_wgt [VTX_N];
        bit [RANKS-1:0][BONE_W-1:0]   rank_bone [VTX_N];
        slot_view_t                   expected_views [$];
        int                           mismatches;
        int                           results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_word(logic [VERTEX_W-1:0] vtx, logic [BONE_W-1:0] bone,
                                logic [WEIGHT_W-1:0] w);
            slot_view_t view;
            int         pos;
            pos = -1;
            for (int s = 0; s < RANKS; s++)
            begin
                if (pos < 0 && rank_wgt[vtx][s] < w)
                    pos = s;
            end
            if (pos >= 0)
            begin
                if (rank_wgt[vtx][pos] != 0)
                begin
                    for (int k = RANKS - 1; k > pos; k--)
                    begin
                        rank_wgt[vtx][k]  = rank_wgt[vtx][k-1];
                        rank_bone[vtx][k] = rank_bone[vtx][k-1];
                    end
                end
                rank_wgt[vtx][pos]  = w;
                rank_bone[vtx][pos] = bone;
            end
            view.hit  = (pos >= 0);
            view.bone = rank_bone[vtx];
            view.wgt  = rank_wgt[vtx];
            expected_views = {expected_views, view};
        endfunction

        function void check_result(slot_view_t got);
            slot_view_t exp_view;
            bit         bad;
            results_seen++;
            if (expected_views.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with no word pending", results_seen);
                mismatches++;
                return;
            end
            exp_view = expected_views.pop_front();
            bad = (got.hit !== exp_view.hit);
            for (int s = 0; s < RANKS; s++)
            begin
                if (got.bone[s] !== exp_view.bone[s] || got.wgt[s] !== exp_view.wgt[s])
                    bad = 1;
            end
            if (bad)
            begin
                if (mismatches < 10)
                    $display({"result %0d: expected acc=%0b bones=%h weights=%h, ",
                              "got acc=%0b bones=%h weights=%h"},
                             results_seen, exp_view.hit, exp_view.bone, exp_view.wgt,
                             got.hit, got.bone, got.wgt);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        function logic [WEIGHT_W-1:0] weight_at(int vtx, int s);
            return rank_wgt[vtx][s];
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [VERTEX_W-1:0] vertex_index;
    logic [BONE_W-1:0]   bone_id;
    logic [WEIGHT_W-1:0] weight;
    logic                out_valid;
    logic                out_ready;
    logic                accepted;
    logic [BONE_W-1:0]   slot0_bone;
    logic [WEIGHT_W-1:0] slot0_weight;
    logic [BONE_W-1:0]   slot1_bone;
    logic [WEIGHT_W-1:0] slot1_weight;
    logic [BONE_W-1:0]   slot2_bone;
    logic [WEIGHT_W-1:0] slot2_weight;
    logic [BONE_W-1:0]   slot3_bone;
    logic [WEIGHT_W-1:0] slot3_weight;

    bone_rank_board sb;
    bit             calm;

    top4_bone_weight_insert_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .bone_id      (bone_id),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .slot0_bone   (slot0_bone),
        .slot0_weight (slot0_weight),
        .slot1_bone   (slot1_bone),
        .slot1_weight (slot1_weight),
        .slot2_bone   (slot2_bone),
        .slot2_weight (slot2_weight),
        .slot3_bone   (slot3_bone),
        .slot3_weight (slot3_weight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_span();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // caller sits just after a falling edge
    task automatic send_word(logic [VERTEX_W-1:0] v, logic [BONE_W-1:0] b,
                             logic [WEIGHT_W-1:0] w);
        int gap;
        gap = idle_span();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        vertex_index = v;
        bone_id      = b;
        weight       = w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(v, b, w);
        @(negedge clk);
    endtask

    // result side: random stalls on out_ready
    initial
    begin
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!calm && $urandom_range(0, 99) < 20)
                    hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        slot_view_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.hit  = accepted;
            got.bone = {slot3_bone, slot2_bone, slot1_bone, slot0_bone};
            got.wgt  = {slot3_weight, slot2_weight, slot1_weight, slot0_weight};
            sb.check_result(got);
        end
    end

    initial
    begin
        #3000000;
        $display("tb_top4_bone_weight_insert_top: FAIL");
        $finish;
    end

    initial
    begin
        int                  hot_base;
        int                  r;
        int                  q;
        logic [VERTEX_W-1:0] v;
        logic [WEIGHT_W-1:0] w;

        sb           = new();
        calm         = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        vertex_index = '0;
        bone_id      = '0;
        weight       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero weight, empty slot fill, ties, full list, drop of the lightest
        send_word(12'd0, 8'h00, 16'h0000);
        send_word(12'd0, 8'hAA, 16'h8000);
        send_word(12'd0, 8'h55, 16'h8000);
        send_word(12'd0, 8'hFF, 16'hFFFF);
        send_word(12'd0, 8'h01, 16'h0001);
        send_word(12'd0, 8'h02, 16'h0001);
        send_word(12'd0, 8'h03, 16'h4000);
        send_word(12'd0, 8'h04, 16'hC000);
        send_word(12'd0, 8'h05, 16'hFFFF);
        send_word(12'd0, 8'h06, 16'h0000);
        send_word(12'd4095, 8'hFF, 16'hFFFF);
        send_word(12'd4095, 8'h00, 16'h0001);
        send_word(12'd4095, 8'h80, 16'h0000);
        send_word(12'd4095, 8'h7F, 16'h0002);
        send_word(12'hAAA, 8'h5A, 16'h5555);
        send_word(12'h555, 8'hA5, 16'hAAAA);
        // back-to-back on one vertex, each loop word heavier, then a reject and a tie
        for (int i = 1; i <= 6; i++)
            send_word(12'd7, 8'(i), 16'(i * 100));
        send_word(12'd7, 8'h11, 16'd50);
        send_word(12'd7, 8'h12, 16'd400);

        for (int blk = 0; blk < 19; blk++)
        begin
            calm     = ($urandom_range(0, 3) == 0);
            hot_base = $urandom_range(0, VTX_N - 16);
            for (int i = 0; i < 100; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    v = 12'(hot_base + $urandom_range(0, 15));
                    q = $urandom_range(0, 99);
                    if (q < 10)
                        w = '0;
                    else if (q < 28)
                        w = sb.weight_at(v, $urandom_range(0, RANKS - 1));
                    else if (q < 36)
                        w = 16'hFFFF;
                    else if (q < 55)
                        w = 16'($urandom_range(1, 255));
                    else
                        w = 16'($urandom);
                end
                else if (r < 90)
                begin
                    v = 12'($urandom_range(0, VTX_N - 1));
                    w = 16'($urandom);
                end
                else
                begin
                    v = 12'(hot_base + $urandom_range(0, 15));
                    w = 16'($urandom_range(0, 1));
                end
                send_word(v, 8'($urandom_range(0, 255)), w);
            end
        end
        in_valid = 1'b0;
        calm     = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top4_bone_weight_insert_top: PASS");
        else
            $display("tb_top4_bone_weight_insert_top: FAIL");
        $finish;
    end

endmodule
